FILE: sv/ttw_pkg.sv
// Shared codes, constants and helper functions for the tap tempo to wiper block.
package ttw_pkg;

	// item commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_TAP   = 2'd1;
	localparam logic [1:0] CMD_POT   = 2'd2;
	localparam logic [1:0] CMD_TABLE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_DIVISION   = 3'd0;
	localparam logic [2:0] REG_DUAL_MODE  = 3'd1;
	localparam logic [2:0] REG_CLEAN_MODE = 3'd2;
	localparam logic [2:0] REG_MAX_TEMPO  = 3'd3;
	localparam logic [2:0] REG_TIMEOUT    = 3'd4;

	localparam logic [10:0] MAX_TEMPO_RESET = 11'd1306;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd2106;
	localparam logic [16:0] TEMPO_MIN       = 17'd37;
	localparam logic [8:0]  POT_MOVE        = 9'd13;
	localparam logic [15:0] MS_MAX          = 16'hFFFF;

	typedef logic [12:0] div_q12_t;

	// Q12 divider for a note division; codes past the list fall back to quarter
	function automatic div_q12_t div_q12(input logic [2:0] division);
		div_q12_t d;
		unique case (division)
			3'd1:    d = 13'd2048;
			3'd2:    d = 13'd3072;
			3'd3:    d = 13'd1365;
			3'd4:    d = 13'd1024;
			3'd5:    d = 13'd683;
			default: d = 13'd4096;
		endcase
		return d;
	endfunction

	// pot * 127 / 255, truncated; reciprocal form exact below 65535
	function automatic logic [7:0] clean_scale(input logic [7:0] pot);
		logic [15:0] x;
		logic [15:0] s;
		x = (16'(pot) << 7) - 16'(pot);
		s = x + (x >> 8) + 16'd1;
		return s[15:8];
	endfunction

endpackage

FILE: sv/ttw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ttw_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/tap_tempo_to_wiper.sv
// Tap tempo detector: counts ms ticks between taps and maps the tempo to a pot wiper.
//
// Input channel (in_valid / in_stall): one item per accept, cmd selects a ms tick,
// a qualified tap press, a time pot sample or a calibration table write.
// Output channel (out_valid / out_stall): exactly one result item per input item,
// in order; wiper_valid marks the items that issue a new wiper position.
// The calibration table sits in a RAM with one registered read port. A tap that
// sets the tempo runs a multiply, a tempo update, one or two end-point reads and
// then, for a tempo between the end points, a binary search, one RAM read per
// cycle with a second read for the neighbor. Ticks, pot samples, table writes and
// the first tap go straight from accept to the push step.
// One item is in work at a time; the next one is taken once the result has moved
// to the output register, so a result may wait there while the next item runs.
// When the receiver stalls, the output register holds its item and the block
// stops at the end of the following item until the register frees.
// Reset clears counters, tempo, mode, last pot value and loads the register
// defaults; table entries are undefined until written.
module tap_tempo_to_wiper #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic        half_ms,
	input  logic [7:0]  pot_value,
	input  logic [7:0]  table_index,
	input  logic [10:0] table_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        wiper_valid,
	output logic [7:0]  wiper,
	output logic [10:0] tempo_ms,
	output logic        tap_mode
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_TEMPO = 4'd2;
	localparam logic [3:0] S_RD0   = 4'd3;
	localparam logic [3:0] S_RDL   = 4'd4;
	localparam logic [3:0] S_MID   = 4'd5;
	localparam logic [3:0] S_NBL   = 4'd6;
	localparam logic [3:0] S_NBH   = 4'd7;
	localparam logic [3:0] S_PUSH  = 4'd8;

	// configuration
	logic [2:0]  division_q;
	logic        dual_q;
	logic        clean_q;
	logic [10:0] max_q;
	logic [15:0] timeout_q;

	// block state
	logic [3:0]  state_q;
	logic [15:0] ms_q;
	logic [1:0]  taps_q;
	logic [10:0] tempo_q;
	logic        mode_tap_q;
	logic [7:0]  last_pot_q;

	// work registers
	logic [28:0]   prod_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [AW-1:0] mid_q;
	logic [10:0]   v_q;
	logic          res_valid_q;
	logic [7:0]    res_wiper_q;

	// output register
	logic        out_valid_q;
	logic        wiper_valid_q;
	logic [7:0]  wiper_q;
	logic [10:0] tempo_out_q;
	logic        tap_mode_q;

	logic          accept;
	logic          out_free;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   tidx_ext;
	logic [10:0]   ram_rdata;
	logic [AW-1:0] rd_addr;

	logic [12:0] dq;
	logic [15:0] ms_inc;
	logic [15:0] ms_half;
	logic [8:0]  pot_diff;
	logic [8:0]  pot_abs;
	logic [7:0]  pot_scaled;
	logic [29:0] avg_sum;
	logic [16:0] t_raw;
	logic [16:0] t_lo;
	logic [16:0] t_cl;
	logic [10:0] tempo_d;

	// search next-state signals
	logic [3:0]    srch_state_d;
	logic [CW-1:0] lo_d;
	logic [CW-1:0] hi_d;
	logic [AW-1:0] mid_d;
	logic          fnd;
	logic [AW-1:0] fnd_idx;
	logic [31:0]   fnd_ext;
	logic          go_loop;
	logic [CW-1:0] lo_n;
	logic [CW-1:0] hi_n;
	logic [CW:0]   msum;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign tidx_ext  = 32'(table_index);
	assign ram_waddr = tidx_ext[AW-1:0];
	assign ram_we    = accept && (cmd == ttw_pkg::CMD_TABLE) &&
	                   (tidx_ext < 32'(TABLE_DEPTH));

	ttw_ram #(
		.WIDTH(11),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (table_value),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// item arithmetic
	always_comb begin
		dq = ttw_pkg::div_q12(division_q);
		if (dual_q) begin
			dq = dq >> 1;
		end
		ms_inc  = (ms_q != ttw_pkg::MS_MAX) ? ms_q + 16'd1 : ms_q;
		ms_half = half_ms ? ms_inc : ms_q;
		pot_diff = {1'b0, last_pot_q} - {1'b0, pot_value};
		pot_abs  = pot_diff[8] ? (9'd0 - pot_diff) : pot_diff;
		pot_scaled = clean_q ? ttw_pkg::clean_scale(pot_value) : pot_value;
		avg_sum = (30'(tempo_q) << 12) + 30'(prod_q) + 30'd4096;
		t_raw   = (taps_q == 2'd1) ? prod_q[28:12] : avg_sum[29:13];
		t_lo    = (t_raw < ttw_pkg::TEMPO_MIN) ? ttw_pkg::TEMPO_MIN : t_raw;
		t_cl    = (t_lo > 17'(max_q)) ? 17'(max_q) : t_lo;
		tempo_d = t_cl[10:0];
	end

	// binary search step: one table read issued per cycle
	always_comb begin
		srch_state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		fnd     = 1'b0;
		fnd_idx = mid_q;
		go_loop = 1'b0;
		lo_n    = lo_q;
		hi_n    = hi_q;
		rd_addr = mid_q;
		msum    = '0;
		unique case (state_q)
			S_TEMPO: begin
				rd_addr      = '0;
				srch_state_d = S_RD0;
			end
			S_RD0: begin
				if (tempo_q <= ram_rdata) begin
					fnd     = 1'b1;
					fnd_idx = '0;
				end else begin
					rd_addr      = LAST_ADDR;
					srch_state_d = S_RDL;
				end
			end
			S_RDL: begin
				if (tempo_q >= ram_rdata) begin
					fnd     = 1'b1;
					fnd_idx = LAST_ADDR;
				end else begin
					go_loop = 1'b1;
					lo_n    = '0;
					hi_n    = DEPTH_C;
				end
			end
			S_MID: begin
				if (ram_rdata == tempo_q) begin
					fnd     = 1'b1;
					fnd_idx = mid_q;
				end else if (tempo_q < ram_rdata) begin
					if (mid_q != '0) begin
						rd_addr      = mid_q - AW'(1);
						srch_state_d = S_NBL;
					end else begin
						go_loop = 1'b1;
						hi_n    = CW'(mid_q);
					end
				end else begin
					if (mid_q != LAST_ADDR) begin
						rd_addr      = mid_q + AW'(1);
						srch_state_d = S_NBH;
					end else begin
						go_loop = 1'b1;
						lo_n    = CW'(mid_q) + CW'(1);
					end
				end
			end
			S_NBL: begin
				// neighbor below mid; v_q holds the mid entry
				if (tempo_q > ram_rdata) begin
					fnd     = 1'b1;
					fnd_idx = ((tempo_q - ram_rdata) >= (v_q - tempo_q)) ?
					          mid_q : mid_q - AW'(1);
				end else begin
					go_loop = 1'b1;
					hi_n    = CW'(mid_q);
				end
			end
			S_NBH: begin
				if (tempo_q < ram_rdata) begin
					fnd     = 1'b1;
					fnd_idx = ((tempo_q - v_q) >= (ram_rdata - tempo_q)) ?
					          mid_q + AW'(1) : mid_q;
				end else begin
					go_loop = 1'b1;
					lo_n    = CW'(mid_q) + CW'(1);
				end
			end
			default: begin
				srch_state_d = state_q;
			end
		endcase
		if (go_loop) begin
			if (lo_n < hi_n) begin
				msum         = {1'b0, lo_n} + {1'b0, hi_n};
				mid_d        = msum[AW:1];
				lo_d         = lo_n;
				hi_d         = hi_n;
				rd_addr      = msum[AW:1];
				srch_state_d = S_MID;
			end else begin
				fnd     = 1'b1;
				fnd_idx = mid_q;
			end
		end
		if (fnd) begin
			srch_state_d = S_PUSH;
		end
	end

	assign fnd_ext = 32'(fnd_idx);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			division_q <= '0;
			dual_q     <= 1'b0;
			clean_q    <= 1'b0;
			max_q      <= ttw_pkg::MAX_TEMPO_RESET;
			timeout_q  <= ttw_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttw_pkg::REG_DIVISION:   division_q <= cfg_data[2:0];
				ttw_pkg::REG_DUAL_MODE:  dual_q     <= cfg_data[0];
				ttw_pkg::REG_CLEAN_MODE: clean_q    <= cfg_data[0];
				ttw_pkg::REG_MAX_TEMPO:  max_q      <= cfg_data[10:0];
				ttw_pkg::REG_TIMEOUT:    timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ms_q        <= '0;
			taps_q      <= '0;
			tempo_q     <= '0;
			mode_tap_q  <= 1'b0;
			last_pot_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_valid_q <= 1'b0;
						state_q     <= S_PUSH;
						unique case (cmd)
							ttw_pkg::CMD_TICK: begin
								if (ms_inc > timeout_q) begin
									ms_q   <= '0;
									taps_q <= '0;
								end else begin
									ms_q <= ms_inc;
								end
							end
							ttw_pkg::CMD_TAP: begin
								if (taps_q == 2'd0) begin
									ms_q   <= '0;
									taps_q <= 2'd1;
								end else begin
									ms_q    <= ms_half;
									state_q <= S_MUL;
								end
							end
							ttw_pkg::CMD_POT: begin
								if (!mode_tap_q || (pot_abs >= ttw_pkg::POT_MOVE)) begin
									last_pot_q  <= pot_scaled;
									mode_tap_q  <= 1'b0;
									res_valid_q <= 1'b1;
									res_wiper_q <= pot_scaled;
								end
							end
							ttw_pkg::CMD_TABLE: ;
							default: ;
						endcase
					end
				end
				S_MUL: begin
					prod_q  <= 29'(ms_q) * 29'(dq);
					state_q <= S_TEMPO;
				end
				S_TEMPO: begin
					tempo_q    <= tempo_d;
					taps_q     <= (taps_q != 2'd3) ? taps_q + 2'd1 : taps_q;
					ms_q       <= '0;
					mode_tap_q <= 1'b1;
					state_q    <= srch_state_d;
				end
				S_RD0, S_RDL, S_MID, S_NBL, S_NBH: begin
					state_q <= srch_state_d;
					lo_q    <= lo_d;
					hi_q    <= hi_d;
					mid_q   <= mid_d;
					if (state_q == S_MID) begin
						v_q <= ram_rdata;
					end
					if (fnd) begin
						res_valid_q <= 1'b1;
						res_wiper_q <= fnd_ext[7:0];
					end
				end
				S_PUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_PUSH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_PUSH) && out_free) begin
			wiper_valid_q <= res_valid_q;
			wiper_q       <= res_valid_q ? res_wiper_q : 8'd0;
			tempo_out_q   <= tempo_q;
			tap_mode_q    <= mode_tap_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign wiper_valid = wiper_valid_q;
	assign wiper       = wiper_q;
	assign tempo_ms    = tempo_out_q;
	assign tap_mode    = tap_mode_q;

`ifndef SYNTHESIS
	a_tempo_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEMPO) |=> ((17'(tempo_q) >= ttw_pkg::TEMPO_MIN) || (tempo_q == max_q)))
		else $error("tempo left the clip range after a tap");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MID) |-> ((lo_q < hi_q) && (32'(mid_q) < 32'(TABLE_DEPTH))))
		else $error("binary search window empty or mid out of table");

	a_tap_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == ttw_pkg::CMD_TAP)) |=> (taps_q != 2'd0))
		else $error("tap press left the tap count at zero");

	a_out_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PUSH))
		else $error("result item issued outside the push step");
`endif

endmodule

FILE: tb/tap_tempo_to_wiper_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tap tempo to wiper block.
module tap_tempo_to_wiper_test;

	localparam int TABLE_DEPTH   = 256;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SEGMENT_ITEMS = 40;

	typedef struct packed {
		logic        issued;
		logic [7:0]  position;
		logic [10:0] tempo;
		logic        tapped;
	} wiper_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = ttw_pkg::CMD_TICK;
	logic        half_ms = 1'b0;
	logic [7:0]  pot_value = '0;
	logic [7:0]  table_index = '0;
	logic [10:0] table_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        wiper_valid;
	logic [7:0]  wiper;
	logic [10:0] tempo_ms;
	logic        tap_mode;

	// block state as the predictor tracks it
	logic [15:0] ms_elapsed = '0;
	logic [1:0]  tap_total = '0;
	logic [10:0] tempo_now = '0;
	logic        tap_ctrl = 1'b0;
	logic [7:0]  pot_held = '0;
	logic [10:0] cal_ms [TABLE_DEPTH];
	logic [2:0]  note_div = '0;
	logic        dual_on = 1'b0;
	logic        clean_on = 1'b0;
	logic [10:0] tempo_cap = ttw_pkg::MAX_TEMPO_RESET;
	logic [15:0] tap_timeout = ttw_pkg::TIMEOUT_RESET;

	wiper_item_t wiper_outcomes [$];
	wiper_item_t got;
	wiper_item_t want;
	int          send_idle_pct = 37;
	int          recv_idle_pct = 87;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	tap_tempo_to_wiper #(.TABLE_DEPTH(TABLE_DEPTH)) uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

	function automatic logic [7:0] nearest_position(input int target);
		int lo, hi, mid, here;
		lo = 0;
		hi = TABLE_DEPTH;
		mid = 0;
		if (target <= int'(cal_ms[0]))
			return 8'd0;
		if (target >= int'(cal_ms[TABLE_DEPTH - 1]))
			return 8'(TABLE_DEPTH - 1);
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			here = int'(cal_ms[mid]);
			if (here == target)
				return 8'(mid);
			// a tie between two neighbors goes to the upper entry
			if (target < here) begin
				if (mid > 0 && target > int'(cal_ms[mid - 1]))
					return (target - int'(cal_ms[mid - 1]) >= here - target) ?
						8'(mid) : 8'(mid - 1);
				hi = mid;
			end else begin
				if (mid < TABLE_DEPTH - 1 && target < int'(cal_ms[mid + 1]))
					return (target - here >= int'(cal_ms[mid + 1]) - target) ?
						8'(mid + 1) : 8'(mid);
				lo = mid + 1;
			end
		end
		return 8'(mid);
	endfunction

	function automatic wiper_item_t next_wiper(input logic [1:0] c, input logic h,
			input logic [7:0] p, input logic [7:0] ti, input logic [10:0] tv);
		wiper_item_t r;
		int unsigned dq;
		int unsigned span;
		int unsigned t;
		int delta;
		r = '0;
		case (c)
			ttw_pkg::CMD_TICK: begin
				if (ms_elapsed != ttw_pkg::MS_MAX)
					ms_elapsed = ms_elapsed + 16'd1;
				// drop a tap run that waited too long
				if (ms_elapsed > tap_timeout) begin
					ms_elapsed = '0;
					tap_total = '0;
				end
			end
			ttw_pkg::CMD_TAP: begin
				if (tap_total == 2'd0) begin
					ms_elapsed = '0;
					tap_total = 2'd1;
				end else begin
					case (note_div)
						3'd1: dq = 2048;
						3'd2: dq = 3072;
						3'd3: dq = 1365;
						3'd4: dq = 1024;
						3'd5: dq = 683;
						default: dq = 4096;
					endcase
					if (dual_on)
						dq = dq >> 1;
					if (h && ms_elapsed != ttw_pkg::MS_MAX)
						ms_elapsed = ms_elapsed + 16'd1;
					span = 32'(ms_elapsed) * dq;
					if (tap_total == 2'd1)
						t = span >> 12;
					else
						t = ((32'(tempo_now) << 12) + span + 32'd4096) >> 13;
					if (t < 32'(ttw_pkg::TEMPO_MIN))
						t = 32'(ttw_pkg::TEMPO_MIN);
					if (t > 32'(tempo_cap))
						t = 32'(tempo_cap);
					tempo_now = 11'(t);
					r.issued = 1'b1;
					r.position = nearest_position(int'(tempo_now));
					if (tap_total != 2'd3)
						tap_total = tap_total + 2'd1;
					ms_elapsed = '0;
					tap_ctrl = 1'b1;
				end
			end
			ttw_pkg::CMD_POT: begin
				delta = int'(pot_held) - int'(p);
				if (delta < 0)
					delta = -delta;
				if (!tap_ctrl || delta >= int'(ttw_pkg::POT_MOVE)) begin
					pot_held = clean_on ? 8'((int'(p) * 127) / 255) : p;
					r.issued = 1'b1;
					r.position = pot_held;
					tap_ctrl = 1'b0;
				end
			end
			ttw_pkg::CMD_TABLE: begin
				if (int'(ti) < TABLE_DEPTH)
					cal_ms[ti] = tv;
			end
		endcase
		r.tempo = tempo_now;
		r.tapped = tap_ctrl;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {wiper_valid, wiper, tempo_ms, tap_mode};
			if (wiper_outcomes.size() == 0) begin
				$display("%0t: unexpected result: valid %0b wiper %0d tempo %0d tap %0b",
					$time, got.issued, got.position, got.tempo, got.tapped);
				mismatch_count++;
			end else begin
				want = wiper_outcomes.pop_front();
				if (got !== want) begin
					$display({"%0t: mismatch: expected valid %0b wiper %0d tempo %0d tap %0b,",
						" got valid %0b wiper %0d tempo %0d tap %0b"}, $time,
						want.issued, want.position, want.tempo, want.tapped,
						got.issued, got.position, got.tempo, got.tapped);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_item(input logic [1:0] c, input logic h, input logic [7:0] p,
			input logic [7:0] ti, input logic [10:0] tv);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= c;
		half_ms <= h;
		pot_value <= p;
		table_index <= ti;
		table_value <= tv;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		wiper_outcomes.push_back(next_wiper(c, h, p, ti, tv));
	endtask

	// unused fields carry noise
	task automatic tick(input int count);
		repeat (count)
			send_item(ttw_pkg::CMD_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
				11'($urandom));
	endtask

	task automatic tap(input logic h);
		send_item(ttw_pkg::CMD_TAP, h, 8'($urandom), 8'($urandom), 11'($urandom));
	endtask

	task automatic pot(input logic [7:0] v);
		send_item(ttw_pkg::CMD_POT, 1'($urandom), v, 8'($urandom), 11'($urandom));
	endtask

	task automatic table_write(input logic [7:0] i, input logic [10:0] v);
		send_item(ttw_pkg::CMD_TABLE, 1'($urandom), 8'($urandom), i, v);
	endtask

	// hold the sender until every result is in
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (wiper_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ttw_pkg::REG_DIVISION:   note_div = data[2:0];
			ttw_pkg::REG_DUAL_MODE:  dual_on = data[0];
			ttw_pkg::REG_CLEAN_MODE: clean_on = data[0];
			ttw_pkg::REG_MAX_TEMPO:  tempo_cap = data[10:0];
			ttw_pkg::REG_TIMEOUT:    tap_timeout = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [2:0] d, input logic du, input logic cl,
			input logic [10:0] cap, input logic [15:0] limit);
		write_reg(ttw_pkg::REG_DIVISION, 16'(d));
		write_reg(ttw_pkg::REG_DUAL_MODE, 16'(du));
		write_reg(ttw_pkg::REG_CLEAN_MODE, 16'(cl));
		write_reg(ttw_pkg::REG_MAX_TEMPO, 16'(cap));
		write_reg(ttw_pkg::REG_TIMEOUT, limit);
	endtask

	// fill the whole table in ascending order
	task automatic load_calibration(input int max_step);
		int level;
		level = $urandom_range(40);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			table_write(8'(i), 11'((level > 2047) ? 2047 : level));
			level += $urandom_range(max_step);
		end
	endtask

	task automatic test_pot_samples();
		pot(8'd255);
		pot(8'd0);
		settle();
		write_reg(ttw_pkg::REG_CLEAN_MODE, 16'd1);
		pot(8'd255);
		pot(8'd1);
		settle();
		write_reg(ttw_pkg::REG_CLEAN_MODE, 16'd0);
	endtask

	task automatic test_tap_sequence();
		tap(1'b1);
		tick(5);
		tap(1'b1);
		tap(1'b0);
		pot(pot_held + 8'd12);
		pot(pot_held + 8'd13);
	endtask

	task automatic test_timeout();
		settle();
		write_reg(ttw_pkg::REG_TIMEOUT, 16'd2);
		tick(3);
		tap(1'b0);
		tap(1'b1);
	endtask

	task automatic test_table_edges();
		logic [10:0] first_ms;
		logic [10:0] last_ms;
		first_ms = cal_ms[0];
		last_ms = cal_ms[TABLE_DEPTH - 1];
		table_write(8'd0, 11'd2047);
		tap(1'b0);
		table_write(8'd0, first_ms);
		table_write(8'(TABLE_DEPTH - 1), 11'd0);
		tap(1'b1);
		table_write(8'(TABLE_DEPTH - 1), last_ms);
	endtask

	task automatic test_tempo_limits();
		settle();
		write_reg(ttw_pkg::REG_MAX_TEMPO, 16'd20);
		write_reg(ttw_pkg::REG_DIVISION, 16'd7);
		tap(1'b0);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int sent;
		int pick;
		int span;
		int cap;
		int limit;
		int lo_v;
		int hi_v;
		logic [7:0] idx;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (4) begin
			settle();
			pick = $urandom_range(99);
			cap = (pick < 40) ? $urandom_range(37, 2047) : (pick < 60) ? 2047 :
				(pick < 75) ? 37 : (pick < 85) ? $urandom_range(36) :
				int'(ttw_pkg::MAX_TEMPO_RESET);
			pick = $urandom_range(99);
			limit = (pick < 15) ? 0 : (pick < 60) ? $urandom_range(20, 150) :
				(pick < 80) ? 65535 : int'(ttw_pkg::TIMEOUT_RESET);
			configure(3'($urandom_range(7)), 1'($urandom), 1'($urandom), 11'(cap), 16'(limit));
			sent = 0;
			while (sent < SEGMENT_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 48) begin
					pick = $urandom_range(99);
					span = (pick < 45) ? $urandom_range(25) : (pick < 85) ?
						$urandom_range(25, 80) : $urandom_range(80, 250);
					tick(span);
					tap(1'($urandom));
					sent += span + 1;
				end else if (pick < 63) begin
					tap(1'($urandom));
					sent++;
				end else if (pick < 80) begin
					pot($urandom_range(1) ? 8'($urandom) :
						8'(int'(pot_held) + $urandom_range(26) - 13));
					sent++;
				end else if (pick < 88) begin
					// rewrite one entry between its neighbors
					idx = 8'($urandom);
					lo_v = (idx == 8'd0) ? 0 : int'(cal_ms[idx - 8'd1]);
					hi_v = (idx == 8'(TABLE_DEPTH - 1)) ? 2047 : int'(cal_ms[idx + 8'd1]);
					table_write(idx, 11'($urandom_range(lo_v, hi_v)));
					sent++;
				end else if (pick < 92) begin
					table_write(8'($urandom), 11'($urandom));
					sent++;
				end else if (pick < 96) begin
					span = (tap_timeout < 16'd300) ? int'(tap_timeout) + 1 + $urandom_range(3) :
						$urandom_range(300);
					tick(span);
					sent += span;
				end else begin
					settle();
				end
			end
		end
	endtask

	// tap count holds at its top value over a long run of taps
	task automatic test_count_saturation();
		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(3'd5, 1'b1, 1'b0, 11'd2047, 16'hFFFF);
		tap(1'b0);
		tick(40);
		tap(1'b1);
		tick(30);
		tap(1'b1);
		tick(20);
		tap(1'b0);
		tap(1'b1);
		settle();
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: cycle limit reached, %0d results outstanding", $time,
			wiper_outcomes.size());
		$display("tap_tempo_to_wiper_test NOT OK");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		load_calibration(12);
		test_pot_samples();
		test_tap_sequence();
		test_timeout();
		test_table_edges();
		test_tempo_limits();
		test_random_traffic(37, 87);
		settle();
		load_calibration(2);
		test_random_traffic(87, 37);
		test_random_traffic(0, 0);
		test_count_saturation();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("tap_tempo_to_wiper_test OK");
		else
			$display("tap_tempo_to_wiper_test NOT OK");
		$finish;
	end

endmodule
